// File: rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque block.
// No dependencies; used by bdq_cell, bdq_chain, bounded_deque_unit and the testbench.
package bdq_pkg;

    localparam int DEPTH      = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int GROUP      = 8;
    localparam int NGROUP     = (DEPTH + GROUP - 1) / GROUP;

    typedef logic [ITEM_WIDTH-1:0] item_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_e;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_e;

    // what every cell of the row does on a given cycle
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_SHIFT_IN  = 3'd1,   // take left neighbor (push front)
        OP_SHIFT_OUT = 3'd2,   // take right neighbor (pop front)
        OP_APPEND    = 3'd3,   // first empty cell takes the value (push back)
        OP_DROP_TAIL = 3'd4    // last occupied cell empties (pop back)
    } cell_op_e;

    typedef struct packed {
        cell_op_e op;
        item_t    value;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_GATHER = 1'b1
    } state_e;

endpackage

// File: rtl/bdq_if.sv
// Handshake channel interfaces of the bounded deque: request, response, config.
// No dependencies; uses plain logic widths, not bdq_pkg.
interface bdq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface bdq_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] popped_value;
    logic [1:0]  status_code;
    logic [6:0]  entry_count;

    modport source (output valid, output popped_value, output status_code,
                    output entry_count, input ready);
    modport sink   (input valid, input popped_value, input status_code,
                    input entry_count, output ready);
endinterface

interface bdq_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

// File: rtl/bdq_cell.sv
// One slot of the deque row: an entry register and its occupied flag.
// Depends on bdq_pkg.
module bdq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  bdq_pkg::cell_cmd_t cmd,
    input  bdq_pkg::item_t    left_data,
    input  logic              left_occ,
    input  bdq_pkg::item_t    right_data,
    input  logic              right_occ,
    output bdq_pkg::item_t    data,
    output logic              occ,
    output bdq_pkg::item_t    tap
);

    bdq_pkg::item_t data_reg, data_next;
    logic           occ_reg, occ_next;
    logic           is_tail;

    assign is_tail = occ_reg && !right_occ;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (cmd.op)
            bdq_pkg::OP_HOLD:
            begin
            end
            bdq_pkg::OP_SHIFT_IN:
            begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            bdq_pkg::OP_SHIFT_OUT:
            begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            bdq_pkg::OP_APPEND:
            begin
                if (!occ_reg && left_occ)
                begin
                    data_next = cmd.value;
                    occ_next  = 1'b1;
                end
            end
            bdq_pkg::OP_DROP_TAIL:
            begin
                if (is_tail)
                    occ_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign occ  = occ_reg;
    // only the back entry shows its value; the row ORs these together
    assign tap  = is_tail ? data_reg : '0;

endmodule

// File: rtl/bdq_chain.sv
// Row of deque cells, front at cell 0, plus the registered group stage that
// collects the back entry's value. Depends on bdq_pkg and bdq_cell.
module bdq_chain (
    input  logic               clk,
    input  logic               rst_n,
    input  bdq_pkg::cell_cmd_t cmd,
    input  logic               capture,
    output bdq_pkg::item_t     front_data,
    output bdq_pkg::item_t     back_data
);

    bdq_pkg::item_t data_w [bdq_pkg::DEPTH];
    logic           occ_w  [bdq_pkg::DEPTH];
    bdq_pkg::item_t tap_w  [bdq_pkg::DEPTH];
    bdq_pkg::item_t grp_reg  [bdq_pkg::NGROUP];
    bdq_pkg::item_t grp_next [bdq_pkg::NGROUP];

    genvar i, g;
    generate
        for (i = 0; i < bdq_pkg::DEPTH; i++)
        begin : g_cell
            bdq_pkg::item_t ld, rd;
            logic           lo, ro;
            if (i == 0)
            begin : g_first
                assign ld = cmd.value;
                assign lo = 1'b1;
            end
            else
            begin : g_mid_l
                assign ld = data_w[i-1];
                assign lo = occ_w[i-1];
            end
            if (i == bdq_pkg::DEPTH - 1)
            begin : g_last
                assign rd = '0;
                assign ro = 1'b0;
            end
            else
            begin : g_mid_r
                assign rd = data_w[i+1];
                assign ro = occ_w[i+1];
            end

            bdq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left_data  (ld),
                .left_occ   (lo),
                .right_data (rd),
                .right_occ  (ro),
                .data       (data_w[i]),
                .occ        (occ_w[i]),
                .tap        (tap_w[i])
            );
        end

        for (g = 0; g < bdq_pkg::NGROUP; g++)
        begin : g_grp
            always_comb
            begin
                grp_next[g] = '0;
                for (int k = g * bdq_pkg::GROUP;
                     k < (g + 1) * bdq_pkg::GROUP && k < bdq_pkg::DEPTH; k++)
                    grp_next[g] = grp_next[g] | tap_w[k];
            end

            always_ff @(posedge clk)
            begin
                if (capture)
                    grp_reg[g] <= grp_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        back_data = '0;
        for (int k = 0; k < bdq_pkg::NGROUP; k++)
            back_data = back_data | grp_reg[k];
    end

    assign front_data = data_w[0];

endmodule

// File: rtl/bounded_deque_unit.sv
// Bounded deque top level: request/response channels, capacity register, control.
// Depends on bdq_pkg, bdq_if and bdq_chain.
//
// Bounded double-ended queue of up to 64 32-bit entries held in a row of cells,
// front entry in the first cell. Each request (push back, push front, pop front,
// pop back) gives one response with status, popped value and entry count. Pushes,
// front pops and failed requests reach the response register in the cycle after
// the request transfer; a successful back pop first takes the back entry's value
// through a registered gather stage over the row. One request is in work at a
// time, so a new request is taken once the previous one has reached the response
// register and that register is free or being emptied in the same cycle.
// capacity_limit resets to 64, values above 64 act as 64, and a limit below the
// current count only blocks pushes. Write the capacity only while idle.
module bounded_deque_unit (
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp,
    bdq_cfg_if.sink    cfg
);

    localparam bdq_pkg::count_t DEPTH_CNT = bdq_pkg::CNT_W'(bdq_pkg::DEPTH);

    bdq_pkg::state_e    state_reg, state_next;
    bdq_pkg::count_t    count_reg, count_next;
    logic [6:0]         cap_reg;
    logic               out_valid_reg, out_valid_next;
    bdq_pkg::item_t     out_value_reg, out_value_next;
    bdq_pkg::status_e   out_status_reg, out_status_next;
    bdq_pkg::count_t    out_count_reg, out_count_next;

    bdq_pkg::count_t    eff_cap;
    bdq_pkg::req_e      req_kind;
    bdq_pkg::cell_cmd_t cmd;
    bdq_pkg::item_t     front_data, back_data;
    logic               accept, full, empty;

    assign eff_cap  = (bdq_pkg::CNT_W'(cap_reg) > DEPTH_CNT) ? DEPTH_CNT
                                                            : bdq_pkg::CNT_W'(cap_reg);
    assign req_kind = bdq_pkg::req_e'(req.req_type);
    assign full     = count_reg >= eff_cap;
    assign empty    = count_reg == '0;
    assign req.ready = (state_reg == bdq_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        cmd.op          = bdq_pkg::OP_HOLD;
        cmd.value       = req.item_value[bdq_pkg::ITEM_WIDTH-1:0];

        unique case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = bdq_pkg::STAT_OK;
                    out_count_next  = count_reg;
                    unique case (req_kind)
                        bdq_pkg::REQ_PUSH_BACK, bdq_pkg::REQ_PUSH_FRONT:
                        begin
                            if (full)
                                out_status_next = bdq_pkg::STAT_FULL;
                            else
                            begin
                                cmd.op = (req_kind == bdq_pkg::REQ_PUSH_BACK)
                                         ? bdq_pkg::OP_APPEND : bdq_pkg::OP_SHIFT_IN;
                                count_next     = count_reg + 1'b1;
                                out_count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::REQ_POP_FRONT:
                        begin
                            if (empty)
                                out_status_next = bdq_pkg::STAT_EMPTY;
                            else
                            begin
                                cmd.op         = bdq_pkg::OP_SHIFT_OUT;
                                out_value_next = front_data;
                                count_next     = count_reg - 1'b1;
                                out_count_next = count_reg - 1'b1;
                            end
                        end
                        bdq_pkg::REQ_POP_BACK:
                        begin
                            if (empty)
                                out_status_next = bdq_pkg::STAT_EMPTY;
                            else
                            begin
                                // tail value is captured into the group stage now
                                cmd.op         = bdq_pkg::OP_DROP_TAIL;
                                count_next     = count_reg - 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = bdq_pkg::ST_GATHER;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bdq_pkg::ST_GATHER:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = back_data;
                out_status_next = bdq_pkg::STAT_OK;
                out_count_next  = count_reg;
                state_next      = bdq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    bdq_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .capture    (accept),
        .front_data (front_data),
        .back_data  (back_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= 7'(bdq_pkg::DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                cap_reg <= cfg.capacity_limit;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = 32'(out_value_reg);
    assign rsp.status_code  = out_status_reg;
    assign rsp.entry_count  = 7'(out_count_reg);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above depth");

    a_gather_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bdq_pkg::ST_GATHER |-> !out_valid_reg)
        else $error("response register busy during gather");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && empty && (req_kind == bdq_pkg::REQ_POP_FRONT ||
                            req_kind == bdq_pkg::REQ_POP_BACK)
        |=> rsp.valid && rsp.status_code == bdq_pkg::STAT_EMPTY && count_reg == '0)
        else $error("pop from empty not flagged");

    a_gather_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bdq_pkg::ST_GATHER |=> rsp.valid &&
                                             rsp.status_code == bdq_pkg::STAT_OK)
        else $error("back pop result missing");

    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status_code != bdq_pkg::STAT_OK |-> rsp.popped_value == '0)
        else $error("failed request carries a value");
`endif

endmodule

// File: sim/bounded_deque_unit_test.sv
// Self-checking testbench for bounded_deque_unit: directed and random deque traffic
// with random stalls on both channels, checked against a shadow deque in a class.
// Depends on bdq_pkg, the bdq_*_if interfaces and the bounded_deque_unit RTL.
module bounded_deque_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bdq_pkg::item_t      popped;
        bdq_pkg::status_e    status;
        bdq_pkg::count_t     count;
    } outcome_t;

    // Shadow deque: mirrors the block's state and holds the outcomes still owed.
    class deque_tracker;
        bdq_pkg::item_t slots[bdq_pkg::DEPTH];
        int         head;
        int         tail;
        int         held;
        int         cap_reg;
        outcome_t   pending_outcomes[$];
        int         mismatches;
        int         n_push;
        int         n_pop;
        int         n_full;
        int         n_empty;

        function new();
            head       = 0;
            tail       = 0;
            held       = 0;
            cap_reg    = 64;
            mismatches = 0;
            n_push     = 0;
            n_pop      = 0;
            n_full     = 0;
            n_empty    = 0;
        endfunction

        function void take_request(bdq_pkg::req_e kind, bdq_pkg::item_t value);
            outcome_t o;
            int       limit;
            o.popped = '0;
            o.status = bdq_pkg::STAT_OK;
            limit = (cap_reg > bdq_pkg::DEPTH) ? bdq_pkg::DEPTH : cap_reg;
            if (kind == bdq_pkg::REQ_PUSH_BACK || kind == bdq_pkg::REQ_PUSH_FRONT) begin
                n_push++;
                if (held >= limit) begin
                    o.status = bdq_pkg::STAT_FULL;
                    n_full++;
                end
                else if (kind == bdq_pkg::REQ_PUSH_BACK) begin
                    slots[tail] = value;
                    tail = (tail + 1) % bdq_pkg::DEPTH;
                    held++;
                end
                else begin
                    head = (head + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
                    slots[head] = value;
                    held++;
                end
            end
            else begin
                n_pop++;
                if (held == 0) begin
                    o.status = bdq_pkg::STAT_EMPTY;
                    n_empty++;
                end
                else if (kind == bdq_pkg::REQ_POP_FRONT) begin
                    o.popped = slots[head];
                    head = (head + 1) % bdq_pkg::DEPTH;
                    held--;
                end
                else begin
                    tail = (tail + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
                    o.popped = slots[tail];
                    held--;
                end
            end
            o.count = bdq_pkg::count_t'(held);
            pending_outcomes.push_back(o);
        endfunction

        function void match_response(bdq_pkg::item_t popped, logic [1:0] status,
                                     bdq_pkg::count_t count);
            outcome_t o;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: popped %h status %0d count %0d",
                             popped, status, count);
            end
            else begin
                o = pending_outcomes.pop_front();
                if (popped !== o.popped || status !== o.status || count !== o.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp popped %h status %0d count %0d, got %h %0d %0d",
                                 o.popped, o.status, o.count, popped, status, count);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bdq_req_if req_ch();
    bdq_rsp_if rsp_ch();
    bdq_cfg_if cfg_ch();

    bounded_deque_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    deque_tracker tracker = new();
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int cap_writes     = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.match_response(rsp_ch.popped_value, rsp_ch.status_code,
                                   rsp_ch.entry_count);
    end

    // Called at a falling edge; returns at the falling edge after the transfer,
    // with valid still high so back-to-back requests need no gap.
    task automatic send_request(bdq_pkg::req_e kind, bdq_pkg::item_t value);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.req_type   = kind;
        req_ch.item_value = value;
        do @(posedge clk); while (!req_ch.ready);
        tracker.take_request(kind, value);
        @(negedge clk);
    endtask

    task automatic drain_responses();
        req_ch.valid = 1'b0;
        while (tracker.pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Only called with the block idle (after drain_responses).
    task automatic write_capacity(int value);
        cfg_ch.valid          = 1'b1;
        cfg_ch.capacity_limit = 7'(value);
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.cap_reg = value;
        cap_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic directed_checks();
        send_request(bdq_pkg::REQ_POP_FRONT, 32'h1234_5678);
        send_request(bdq_pkg::REQ_POP_BACK, 32'hFFFF_FFFF);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'h0000_0000);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(bdq_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5);
        send_request(bdq_pkg::REQ_PUSH_FRONT, 32'h5A5A_5A5A);
        send_request(bdq_pkg::REQ_POP_BACK, 32'h0);
        send_request(bdq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(bdq_pkg::REQ_POP_BACK, 32'h0);
        send_request(bdq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(bdq_pkg::REQ_POP_FRONT, 32'h0);
        drain_responses();
        write_capacity(1);
        send_request(bdq_pkg::REQ_PUSH_FRONT, 32'h0000_0001);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'h8000_0000);
        send_request(bdq_pkg::REQ_POP_BACK, 32'h0);
        send_request(bdq_pkg::REQ_POP_BACK, 32'h0);
        drain_responses();
        // zero capacity: every push is rejected as full
        write_capacity(0);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'hDEAD_BEEF);
        send_request(bdq_pkg::REQ_PUSH_FRONT, 32'hCAFE_F00D);
        drain_responses();
        // above depth saturates to DEPTH
        write_capacity(127);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'h1111_1111);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'h2222_2222);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'h3333_3333);
        drain_responses();
        // limit dropped below the held count: entries stay, pushes blocked until pops bring the count under the limit
        write_capacity(2);
        send_request(bdq_pkg::REQ_PUSH_FRONT, 32'h4444_4444);
        send_request(bdq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(bdq_pkg::REQ_PUSH_BACK, 32'h5555_5555);
        send_request(bdq_pkg::REQ_POP_BACK, 32'h0);
        send_request(bdq_pkg::REQ_PUSH_FRONT, 32'h6666_6666);
        drain_responses();
    endtask

    // Bursts lean toward pushes or pops so the deque swings between empty and full.
    task automatic random_traffic(int n_items);
        int             push_pct;
        int             burst_left;
        bit             is_push;
        bit             coin;
        bdq_pkg::req_e  kind;
        bdq_pkg::item_t value;
        burst_left = 0;
        push_pct   = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(20, 100);
                case ($urandom_range(0, 4))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    2: push_pct = 70;
                    3: push_pct = 30;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            is_push = ($urandom_range(0, 99) < push_pct);
            coin    = 1'($urandom_range(0, 1));
            if (is_push)
                kind = coin ? bdq_pkg::REQ_PUSH_BACK : bdq_pkg::REQ_PUSH_FRONT;
            else
                kind = coin ? bdq_pkg::REQ_POP_FRONT : bdq_pkg::REQ_POP_BACK;
            case ($urandom_range(0, 9))
                0: value = '0;
                1: value = '1;
                default: value = $urandom;
            endcase
            send_request(kind, value);
        end
    endtask

    initial
    begin
        int cap_plan[12];
        int gap_plan[3];
        int stall_plan[3];
        int fails;
        int cap;

        cap_plan   = '{64, 127, 3, 1, 40, 0, 65, 2, 64, 17, 96, 64};
        gap_plan   = '{19, 57, 0};
        stall_plan = '{57, 19, 0};

        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = bdq_pkg::REQ_PUSH_BACK;
        req_ch.item_value     = '0;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.capacity_limit = 7'd64;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_checks();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap_pct   = gap_plan[phase];
            recv_stall_pct = stall_plan[phase];
            for (int seg = 0; seg < 4; seg++)
            begin
                cap = (phase * 4 + seg == 9) ? $urandom_range(1, 64)
                                             : cap_plan[phase * 4 + seg];
                drain_responses();
                write_capacity(cap);
                random_traffic(125);
            end
        end

        drain_responses();
        repeat (10) @(negedge clk);

        fails = tracker.mismatches + tracker.pending_outcomes.size();
        $display("covered %0d pushes (%0d rejected full) and %0d pops (%0d on empty)",
                 tracker.n_push, tracker.n_full, tracker.n_pop, tracker.n_empty);
        $display("capacity written %0d times across 0..127, %0d failures",
                 cap_writes, fails);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_cell.sv
rtl/bdq_chain.sv
rtl/bounded_deque_unit.sv
sim/bounded_deque_unit_test.sv
